// ===== hw/rtl/fkuec_pkg.sv =====
// Package for the flash key unlock and erase control block.
// Holds register codes, unlock phases, key values, control bit positions and the sector table.
// Has no dependencies; used by fkuec_regfile and flash_key_unlock_erase_control_core.
package fkuec_pkg;

	localparam int DATA_W = 32;
	localparam int ADDR_W = 21;
	localparam int SNB_W = 5;
	localparam int SECTOR_TOTAL = 24;

	// Register index codes.
	localparam logic [2:0] REG_ACCESS_CTRL = 3'd0;
	localparam logic [2:0] REG_KEY = 3'd1;
	localparam logic [2:0] REG_OPT_KEY = 3'd2;
	localparam logic [2:0] REG_STATUS = 3'd3;
	localparam logic [2:0] REG_CONTROL = 3'd4;
	localparam logic [2:0] REG_OPTION = 3'd5;
	localparam logic [2:0] REG_OPTION_HIGH = 3'd6;

	localparam logic CMD_READ = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	typedef enum logic [1:0] {
		PH_LOCKED = 2'd0,
		PH_KEY1 = 2'd1,
		PH_UNLOCKED = 2'd2
	} phase_t;

	localparam logic [DATA_W-1:0] KEY_ONE = 32'h4567_0123;
	localparam logic [DATA_W-1:0] KEY_TWO = 32'hCDEF_89AB;
	localparam logic [DATA_W-1:0] OPTION_RESET = 32'h0FFF_AAED;
	localparam logic [DATA_W-1:0] OPTION_HIGH_RESET = 32'h0FFF_0000;

	localparam int BIT_LOCK = 31;
	localparam int BIT_START = 16;
	localparam int BIT_SER = 1;
	localparam int BIT_WRPERR = 4;
	localparam int SNB_LSB = 3;

	localparam logic [ADDR_W-1:0] SECT_FIRST [SECTOR_TOTAL] = '{
		21'd0, 21'd16384, 21'd32768, 21'd49152, 21'd65536, 21'd131072,
		21'd262144, 21'd393216, 21'd524288, 21'd655360, 21'd786432, 21'd917504,
		21'd1048576, 21'd1064960, 21'd1081344, 21'd1097728, 21'd1114112,
		21'd1179648, 21'd1310720, 21'd1441792, 21'd1572864, 21'd1703936,
		21'd1835008, 21'd1966080
	};

	localparam logic [ADDR_W-1:0] SECT_LAST [SECTOR_TOTAL] = '{
		21'd16383, 21'd32767, 21'd49151, 21'd65535, 21'd131071, 21'd262143,
		21'd393215, 21'd524287, 21'd655359, 21'd786431, 21'd917503, 21'd1048575,
		21'd1064959, 21'd1081343, 21'd1097727, 21'd1114111, 21'd1179647,
		21'd1310719, 21'd1441791, 21'd1572863, 21'd1703935, 21'd1835007,
		21'd1966079, 21'd2097151
	};

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic erase_valid;
		logic [ADDR_W-1:0] erase_first_byte;
		logic [ADDR_W-1:0] erase_last_byte;
		logic flash_writable;
	} result_t;

	function automatic logic [ADDR_W-1:0] sector_first(input logic [SNB_W-1:0] snb);
		logic [ADDR_W-1:0] r;
		r = '0;
		if (snb < SNB_W'(SECTOR_TOTAL)) begin
			r = SECT_FIRST[snb];
		end
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] sector_last(input logic [SNB_W-1:0] snb);
		logic [ADDR_W-1:0] r;
		r = '0;
		if (snb < SNB_W'(SECTOR_TOTAL)) begin
			r = SECT_LAST[snb];
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/fkuec_regfile.sv =====
// Register file and unlock sequencer of the flash key unlock and erase control block.
// Decodes one register access per enabled cycle and updates the state at the clock edge.
// Depends on fkuec_pkg.
module fkuec_regfile #(
	parameter int SECTOR_COUNT = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     cmd,
	input  logic [2:0]               idx,
	input  logic [fkuec_pkg::DATA_W-1:0] wdata,
	output fkuec_pkg::result_t       res
);

	fkuec_pkg::phase_t phase_q, phase_d;
	logic [fkuec_pkg::DATA_W-1:0] acr_q, acr_d;
	logic [fkuec_pkg::DATA_W-1:0] optkey_q, optkey_d;
	logic [fkuec_pkg::DATA_W-1:0] ctrl_q, ctrl_d;
	logic [fkuec_pkg::DATA_W-1:0] opt_q, opt_d;
	logic [fkuec_pkg::DATA_W-1:0] opth_q, opth_d;
	logic err_q, err_d;

	logic [fkuec_pkg::DATA_W-1:0] cval;
	logic [fkuec_pkg::SNB_W-1:0] snb;
	logic erase_hit;

	always_comb begin
		phase_d = phase_q;
		acr_d = acr_q;
		optkey_d = optkey_q;
		ctrl_d = ctrl_q;
		opt_d = opt_q;
		opth_d = opth_q;
		err_d = err_q;
		cval = wdata;
		snb = wdata[fkuec_pkg::SNB_LSB +: fkuec_pkg::SNB_W];
		erase_hit = 1'b0;
		res.read_data = '0;

		if (cmd == fkuec_pkg::CMD_READ) begin
			case (idx)
				fkuec_pkg::REG_ACCESS_CTRL: res.read_data = acr_q;
				fkuec_pkg::REG_OPT_KEY:     res.read_data = optkey_q;
				fkuec_pkg::REG_STATUS: begin
					res.read_data[fkuec_pkg::BIT_WRPERR] = err_q;
				end
				fkuec_pkg::REG_CONTROL: begin
					// A control read refreshes the stored lock bit from the phase.
					ctrl_d[fkuec_pkg::BIT_LOCK] = (phase_q != fkuec_pkg::PH_UNLOCKED);
					res.read_data = ctrl_d;
				end
				fkuec_pkg::REG_OPTION:      res.read_data = opt_q;
				fkuec_pkg::REG_OPTION_HIGH: res.read_data = opth_q;
				default:                    res.read_data = '0;
			endcase
		end else begin
			// Any write other than a key transfer breaks a pending key sequence.
			if (phase_q == fkuec_pkg::PH_KEY1 && idx != fkuec_pkg::REG_KEY) begin
				phase_d = fkuec_pkg::PH_LOCKED;
			end
			case (idx)
				fkuec_pkg::REG_ACCESS_CTRL: acr_d = wdata;
				fkuec_pkg::REG_KEY: begin
					if (wdata == fkuec_pkg::KEY_ONE) begin
						phase_d = fkuec_pkg::PH_KEY1;
					end else if (wdata == fkuec_pkg::KEY_TWO &&
					             phase_q == fkuec_pkg::PH_KEY1) begin
						phase_d = fkuec_pkg::PH_UNLOCKED;
					end
				end
				fkuec_pkg::REG_OPT_KEY: optkey_d = wdata;
				fkuec_pkg::REG_STATUS: begin
					if (wdata[fkuec_pkg::BIT_WRPERR]) begin
						err_d = 1'b0;
					end
				end
				fkuec_pkg::REG_CONTROL: begin
					if (phase_d != fkuec_pkg::PH_UNLOCKED) begin
						cval[fkuec_pkg::BIT_LOCK] = 1'b1;
					end else if (wdata[fkuec_pkg::BIT_LOCK]) begin
						phase_d = fkuec_pkg::PH_LOCKED;
					end
					ctrl_d = cval;
					ctrl_d[fkuec_pkg::BIT_START] = 1'b0;
					if (cval[fkuec_pkg::BIT_START] && cval[fkuec_pkg::BIT_SER]) begin
						if (cval[fkuec_pkg::BIT_LOCK]) begin
							err_d = 1'b1;
						end else if (snb < fkuec_pkg::SNB_W'(SECTOR_COUNT)) begin
							erase_hit = 1'b1;
						end
					end
				end
				fkuec_pkg::REG_OPTION:      opt_d = wdata;
				fkuec_pkg::REG_OPTION_HIGH: opth_d = wdata;
				default: ;
			endcase
		end

		res.erase_valid = erase_hit;
		res.erase_first_byte = erase_hit ? fkuec_pkg::sector_first(snb) : '0;
		res.erase_last_byte = erase_hit ? fkuec_pkg::sector_last(snb) : '0;
		res.flash_writable = (phase_d == fkuec_pkg::PH_UNLOCKED);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fkuec_pkg::PH_LOCKED;
			acr_q <= '0;
			optkey_q <= '0;
			ctrl_q <= '0;
			opt_q <= fkuec_pkg::OPTION_RESET;
			opth_q <= fkuec_pkg::OPTION_HIGH_RESET;
			err_q <= 1'b0;
		end else if (en) begin
			phase_q <= phase_d;
			acr_q <= acr_d;
			optkey_q <= optkey_d;
			ctrl_q <= ctrl_d;
			opt_q <= opt_d;
			opth_q <= opth_d;
			err_q <= err_d;
		end
	end

`ifndef SYNTH
	a_erase_needs_unlock: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.erase_valid |=> phase_q == fkuec_pkg::PH_UNLOCKED)
		else $error("erase started while the flash did not stay unlocked");

	a_key_one_arms: assert property (@(posedge clk) disable iff (!arst_n)
		en && cmd == fkuec_pkg::CMD_WRITE && idx == fkuec_pkg::REG_KEY &&
		wdata == fkuec_pkg::KEY_ONE |=> phase_q == fkuec_pkg::PH_KEY1)
		else $error("first key did not move to the first-key phase");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(phase_q) && $stable(err_q) && $stable(ctrl_q))
		else $error("state changed without an access");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.erase_valid |-> res.erase_first_byte < res.erase_last_byte)
		else $error("erase range is empty or reversed");
`endif

endmodule

// ===== hw/rtl/flash_key_unlock_erase_control_core.sv =====
// Top level of the flash key unlock and erase control block.
// Stream handshake, input register and result register around fkuec_regfile.
// Depends on fkuec_pkg and fkuec_regfile.

// One register access per transfer on the input stream yields exactly one result transfer.
// The block takes a new access every cycle while the output is not stalled; each access
// passes the input register and then the result register. The register file updates its
// state as the access leaves the input register, so back-to-back accesses see each other's
// effects in order. A stalled output stops the input register and then the input stream.
// Writing the two keys in a row to the key register unlocks the flash; a control write with
// start and sector erase reports the chosen sector's byte range, or sets the write-protect
// error when locked. SECTOR_COUNT (12 to 24) limits which sector numbers start an erase.
module flash_key_unlock_erase_control_core #(
	parameter int SECTOR_COUNT = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] write_data
	input  logic [3:0]  s_axis_tuser,  // [0] command, [3:1] reg_index
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [31:0] read_data, [32] erase_valid, [53:33] erase_first_byte,
	// [74:54] erase_last_byte, [75] flash_writable, [79:76] zero
	output logic [79:0] m_axis_tdata
);

	logic valid_s1;
	logic cmd_s1;
	logic [2:0] idx_s1;
	logic [fkuec_pkg::DATA_W-1:0] wdata_s1;
	logic out_valid_q;
	logic [79:0] out_data_q;
	logic advance;
	logic in_xfer;
	fkuec_pkg::result_t res;

	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_s1 <= s_axis_tuser[0];
			idx_s1 <= s_axis_tuser[3:1];
			wdata_s1 <= s_axis_tdata;
		end
	end

	fkuec_regfile #(
		.SECTOR_COUNT(SECTOR_COUNT)
	) u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.cmd    (cmd_s1),
		.idx    (idx_s1),
		.wdata  (wdata_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {4'b0000, res.flash_writable, res.erase_last_byte,
			               res.erase_first_byte, res.erase_valid, res.read_data};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule
